### rtl/threshold_leader_clustering_defines.svh
// Assertion macros for the threshold leader clustering block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
// Simulation builds get the checks; builds with SYNTH defined get empty bodies.
`ifndef THRESHOLD_LEADER_CLUSTERING_DEFINES_SVH
`define THRESHOLD_LEADER_CLUSTERING_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, clocked on aclk, off during reset
`define TLC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tlc: check failed");
// next-cycle implication
`define TLC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tlc: check failed");
`else
`define TLC_ASSERT_IMP(lbl, ante, cons)
`define TLC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/tlc_pkg.sv
// Package for the threshold leader clustering block: item structs, sequencer
// and decision enums, control struct of the distance unit, default constants.
// No dependencies.
package tlc_pkg;

    localparam int MAX_CLUSTERS_DEF = 16;
    localparam int COORD_BITS_DEF   = 16;

    localparam int THR_W    = 34;
    localparam int FIELD_W  = 16;
    localparam int COUNT_W  = 16;
    localparam int WEIGHT_W = 32;
    localparam int IDX_W    = 4;

    typedef struct packed {
        logic                       start_set;
        logic signed [FIELD_W-1:0]  point_x;
        logic signed [FIELD_W-1:0]  point_y;
        logic signed [FIELD_W-1:0]  point_z;
        logic [FIELD_W-1:0]         point_weight;
    } tlc_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]           cluster_index;
        logic                       opened_new;
        logic                       table_full;
        logic [COUNT_W-1:0]         cluster_count;
        logic [WEIGHT_W-1:0]        cluster_weight;
        logic signed [FIELD_W-1:0]  center_x;
        logic signed [FIELD_W-1:0]  center_y;
        logic signed [FIELD_W-1:0]  center_z;
    } tlc_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_CMP,
        ST_FETCH,
        ST_WRITE
    } tlc_state_t;

    typedef enum logic [1:0] {
        ACT_JOIN,
        ACT_FULL,
        ACT_NEW
    } tlc_act_t;

    // control of the shared square-accumulate unit
    typedef struct packed {
        logic ena;    // take one axis this cycle
        logic first;  // first axis of a center: restart the sum
    } tlc_mac_ctl_t;

endpackage

### rtl/tlc_dist_unit.sv
// Shared squared-distance unit: one axis difference squared per cycle while
// ctl.ena is high, registered product, running sum over the three axes.
// Depends on tlc_pkg.
module tlc_dist_unit #(
    parameter int COORD_BITS = tlc_pkg::COORD_BITS_DEF
) (
    input  logic                        aclk,
    input  tlc_pkg::tlc_mac_ctl_t       ctl,
    input  logic signed [COORD_BITS-1:0] a,
    input  logic signed [COORD_BITS-1:0] b,
    output logic [2*COORD_BITS+2:0]     dist_sum
);
    import tlc_pkg::*;

    localparam int SQ_W = 2 * COORD_BITS + 1;
    localparam int DW   = 2 * COORD_BITS + 3;

    logic signed [COORD_BITS:0]     diff;
    logic signed [2*COORD_BITS+1:0] prod_full;
    logic [SQ_W-1:0]                prod_reg;
    logic [DW-1:0]                  acc_reg;

    assign diff      = (COORD_BITS + 1)'(a) - (COORD_BITS + 1)'(b);
    assign prod_full = diff * diff;

    always_ff @(posedge aclk) begin
        if (ctl.ena) begin
            prod_reg <= prod_full[SQ_W-1:0];
            acc_reg  <= ctl.first ? '0 : acc_reg + DW'(prod_reg);
        end
    end

    // valid in the cycle after the third axis is taken
    assign dist_sum = acc_reg + DW'(prod_reg);

endmodule

### rtl/threshold_leader_clustering.sv
// Threshold leader clustering of weighted 3-D points. Each accepted point is
// compared with every cluster center in use (squared Euclidean distance, first
// minimum wins), then joins the nearest cluster when that distance is strictly
// below threshold_sq, opens a new cluster otherwise, or is dropped with
// table_full when all MAX_CLUSTERS entries are in use. One result item per
// point. A point steps from acceptance to its result through load, a multiply
// step per axis plus a compare per center in use, fetch and write; with an
// empty table or start_set it goes straight to fetch and write. One squarer is
// shared over the three axes. s_ready is high only between points, once the
// result is registered, so a new point is taken only after the last one is
// through; the write step waits while an earlier result is still held. The
// output register holds a result until taken, while the next point already
// runs. The threshold is to be written through cfg_wr_en/cfg_wr_data by the
// user only while idle; the block itself does not enforce it.
`include "threshold_leader_clustering_defines.svh"
module threshold_leader_clustering #(
    parameter int MAX_CLUSTERS = tlc_pkg::MAX_CLUSTERS_DEF,
    parameter int COORD_BITS   = tlc_pkg::COORD_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [tlc_pkg::THR_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  tlc_pkg::tlc_in_t          s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output tlc_pkg::tlc_out_t         m_data
);
    import tlc_pkg::*;

    localparam int IW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int UW = $clog2(MAX_CLUSTERS + 1);
    localparam int DW = 2 * COORD_BITS + 3;
    localparam int CW = (DW > THR_W) ? DW : THR_W;
    localparam logic [UW-1:0] USED_MAX = UW'(MAX_CLUSTERS);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // cluster table: one write port, one registered read port
    logic [2:0][COORD_BITS-1:0] ctr_mem [MAX_CLUSTERS];
    logic [COUNT_W-1:0]         cnt_mem [MAX_CLUSTERS];
    logic [WEIGHT_W-1:0]        wgt_mem [MAX_CLUSTERS];

    logic                       rd_en, wr_en;
    logic [IW-1:0]              rd_addr, wr_addr;
    logic [2:0][COORD_BITS-1:0] rd_ctr_reg, wr_ctr;
    logic [COUNT_W-1:0]         rd_cnt_reg, wr_cnt;
    logic [WEIGHT_W-1:0]        rd_wgt_reg, wr_wgt;

    tlc_state_t          state_reg, state_next;
    tlc_act_t            act_reg, act_next;
    logic [UW-1:0]       used_reg, used_next;
    logic [IW-1:0]       scan_idx_reg, scan_idx_next;
    logic [IW-1:0]       best_idx_reg, best_idx_next;
    logic [DW-1:0]       best_d_reg, best_d_next;
    logic                found_reg, found_next;
    logic [1:0]          axis_reg, axis_next;
    logic [THR_W-1:0]    thr_reg;
    logic [2:0][COORD_BITS-1:0] pt_reg, pt_next;
    logic [FIELD_W-1:0]  pw_reg, pw_next;
    logic                m_valid_reg, m_valid_next;
    tlc_out_t            m_data_reg, m_data_next;

    logic                accept, slot_free, last_center;
    tlc_mac_ctl_t        mac_ctl;
    coord_t              mac_a, mac_b;
    logic [DW-1:0]       mac_dist;
    logic [COUNT_W-1:0]  cnt_inc;
    logic [WEIGHT_W:0]   wgt_sum;
    logic [WEIGHT_W-1:0] wgt_sat;

    // stored coordinate to 16-bit output field (sign-extends narrow widths)
    function automatic logic [FIELD_W-1:0] ctr_field(input coord_t v);
        return FIELD_W'(v);
    endfunction

    assign accept      = s_valid && s_ready;
    assign slot_free   = !m_valid_reg || m_ready;
    assign last_center = (UW'(scan_idx_reg) + UW'(1)) == used_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- shared distance unit ----------------
    always_comb begin
        case (axis_reg)
            2'd0:    begin mac_a = coord_t'(rd_ctr_reg[0]); mac_b = coord_t'(pt_reg[0]); end
            2'd1:    begin mac_a = coord_t'(rd_ctr_reg[1]); mac_b = coord_t'(pt_reg[1]); end
            2'd2:    begin mac_a = coord_t'(rd_ctr_reg[2]); mac_b = coord_t'(pt_reg[2]); end
            default: begin mac_a = '0; mac_b = '0; end
        endcase
    end

    assign mac_ctl.ena   = (state_reg == ST_MUL);
    assign mac_ctl.first = (axis_reg == 2'd0);

    tlc_dist_unit #(
        .COORD_BITS(COORD_BITS)
    ) u_dist (
        .aclk     (aclk),
        .ctl      (mac_ctl),
        .a        (mac_a),
        .b        (mac_b),
        .dist_sum (mac_dist)
    );

    // join update, both saturating
    assign cnt_inc = (rd_cnt_reg == {COUNT_W{1'b1}}) ? rd_cnt_reg : rd_cnt_reg + COUNT_W'(1);
    assign wgt_sum = {1'b0, rd_wgt_reg} + (WEIGHT_W + 1)'(pw_reg);
    assign wgt_sat = wgt_sum[WEIGHT_W] ? {WEIGHT_W{1'b1}} : wgt_sum[WEIGHT_W-1:0];

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.start_set || used_reg == '0) state_next = ST_FETCH;
                    else                                     state_next = ST_LOAD;
                end
            end
            ST_LOAD:  state_next = ST_MUL;
            ST_MUL:   if (axis_reg == 2'd2) state_next = ST_CMP;
            ST_CMP:   state_next = last_center ? ST_FETCH : ST_MUL;
            ST_FETCH: state_next = ST_WRITE;
            ST_WRITE: if (slot_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---------------- datapath and table control ----------------
    always_comb begin
        act_next      = act_reg;
        used_next     = used_reg;
        scan_idx_next = scan_idx_reg;
        best_idx_next = best_idx_reg;
        best_d_next   = best_d_reg;
        found_next    = found_reg;
        axis_next     = axis_reg;
        pt_next       = pt_reg;
        pw_next       = pw_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        rd_en         = 1'b0;
        rd_addr       = scan_idx_reg;
        wr_en         = 1'b0;
        wr_addr       = best_idx_reg;
        wr_ctr        = rd_ctr_reg;
        wr_cnt        = cnt_inc;
        wr_wgt        = wgt_sat;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    // coordinates read as COORD_BITS-bit two's complement
                    pt_next[0]    = COORD_BITS'($unsigned(s_data.point_x));
                    pt_next[1]    = COORD_BITS'($unsigned(s_data.point_y));
                    pt_next[2]    = COORD_BITS'($unsigned(s_data.point_z));
                    pw_next       = s_data.point_weight;
                    scan_idx_next = '0;
                    best_idx_next = '0;
                    found_next    = 1'b0;
                    if (s_data.start_set) used_next = '0;
                end
            end
            ST_LOAD: begin
                rd_en     = 1'b1;
                axis_next = 2'd0;
            end
            ST_MUL: begin
                axis_next = axis_reg + 2'd1;
            end
            ST_CMP: begin
                // strict compare keeps the first minimum
                if (!found_reg || mac_dist < best_d_reg) begin
                    best_d_next   = mac_dist;
                    best_idx_next = scan_idx_reg;
                end
                found_next = 1'b1;
                axis_next  = 2'd0;
                if (!last_center) begin
                    scan_idx_next = scan_idx_reg + IW'(1);
                    rd_en         = 1'b1;
                    rd_addr       = scan_idx_reg + IW'(1);
                end
            end
            ST_FETCH: begin
                rd_en   = 1'b1;
                rd_addr = best_idx_reg;
                if (found_reg && CW'(best_d_reg) < CW'(thr_reg))
                    act_next = ACT_JOIN;
                else if (used_reg == USED_MAX)
                    act_next = ACT_FULL;
                else
                    act_next = ACT_NEW;
            end
            ST_WRITE: begin
                if (slot_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next.cluster_index   = IDX_W'(best_idx_reg);
                    m_data_next.opened_new      = 1'b0;
                    m_data_next.table_full      = 1'b0;
                    m_data_next.cluster_count   = rd_cnt_reg;
                    m_data_next.cluster_weight  = rd_wgt_reg;
                    m_data_next.center_x        = ctr_field(coord_t'(rd_ctr_reg[0]));
                    m_data_next.center_y        = ctr_field(coord_t'(rd_ctr_reg[1]));
                    m_data_next.center_z        = ctr_field(coord_t'(rd_ctr_reg[2]));
                    case (act_reg)
                        ACT_JOIN: begin
                            wr_en                      = 1'b1;
                            m_data_next.cluster_count  = cnt_inc;
                            m_data_next.cluster_weight = wgt_sat;
                        end
                        ACT_FULL: begin
                            m_data_next.table_full = 1'b1;
                        end
                        ACT_NEW: begin
                            wr_en                       = 1'b1;
                            wr_addr                     = used_reg[IW-1:0];
                            wr_ctr                      = pt_reg;
                            wr_cnt                      = COUNT_W'(1);
                            wr_wgt                      = WEIGHT_W'(pw_reg);
                            used_next                   = used_reg + UW'(1);
                            m_data_next.cluster_index   = IDX_W'(used_reg[IW-1:0]);
                            m_data_next.opened_new      = 1'b1;
                            m_data_next.cluster_count   = COUNT_W'(1);
                            m_data_next.cluster_weight  = WEIGHT_W'(pw_reg);
                            m_data_next.center_x        = ctr_field(coord_t'(pt_reg[0]));
                            m_data_next.center_y        = ctr_field(coord_t'(pt_reg[1]));
                            m_data_next.center_z        = ctr_field(coord_t'(pt_reg[2]));
                        end
                        default: begin
                            m_data_next.table_full = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- table memory ----------------
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ctr_mem[wr_addr] <= wr_ctr;
            cnt_mem[wr_addr] <= wr_cnt;
            wgt_mem[wr_addr] <= wr_wgt;
        end
        if (rd_en) begin
            rd_ctr_reg <= ctr_mem[rd_addr];
            rd_cnt_reg <= cnt_mem[rd_addr];
            rd_wgt_reg <= wgt_mem[rd_addr];
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
            thr_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) thr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        scan_idx_reg <= scan_idx_next;
        best_idx_reg <= best_idx_next;
        best_d_reg   <= best_d_next;
        found_reg    <= found_next;
        axis_reg     <= axis_next;
        pt_reg       <= pt_next;
        pw_reg       <= pw_next;
        m_data_reg   <= m_data_next;
    end

    // ---------------- checks ----------------
    `TLC_ASSERT_IMP(a_used_bound, 1'b1, used_reg <= USED_MAX)
    `TLC_ASSERT_IMP(a_scan_in_use, state_reg == ST_MUL, UW'(scan_idx_reg) < used_reg)
    `TLC_ASSERT_NXT(a_new_bump, wr_en && act_reg == ACT_NEW, used_reg == $past(used_reg) + UW'(1))
    `TLC_ASSERT_IMP(a_flags_excl, m_valid_reg, !(m_data_reg.opened_new && m_data_reg.table_full))
    `TLC_ASSERT_NXT(a_full_hold, state_reg == ST_WRITE && act_reg == ACT_FULL, used_reg == USED_MAX)

endmodule
